/* rtl/core/pidc_pkg.sv */
`timescale 1ns / 1ps
package pidc_pkg;

   localparam int FILTER_DEPTH = 5;
   localparam int DATA_W = 32;
   localparam int DT_W = 16;
   localparam int LIM_W = 31;
   localparam int FRAC_W = 16;
   localparam int MUL_W = 32;
   localparam int DIV_W = DATA_W + 1 + FRAC_W;
   localparam int DEN_W = 16;
   localparam int OUT_W = 2 * MUL_W - FRAC_W + 2;
   localparam int SUM_W = DATA_W + $clog2(FILTER_DEPTH);
   localparam int IDX_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
   localparam int CNT_W = $clog2(FILTER_DEPTH + 1);
   localparam logic [FRAC_W-1:0] DECAY_Q16 = 16'd62259;

   typedef enum logic [2:0] {
      REG_PROP_GAIN,
      REG_INTEG_GAIN,
      REG_DERIV_GAIN,
      REG_OUT_MIN,
      REG_OUT_MAX,
      REG_INTEG_LIMIT,
      REG_DEAD_BAND,
      REG_INTEG_REGION
   } reg_index_type;

   typedef enum logic [1:0] {
      HIT_NONE = 2'd0,
      HIT_MAX  = 2'd1,
      HIT_MIN  = 2'd2
   } limit_code_type;

endpackage

/* rtl/core/pidc_req_if.sv */
`timescale 1ns / 1ps
interface pidc_req_if;
   logic                              valid;
   logic                              ready;
   logic                              restart;
   logic signed [pidc_pkg::DATA_W-1:0] error_in;
   logic [pidc_pkg::DT_W-1:0]         step_time;

   modport source (output valid, restart, error_in, step_time, input ready);
   modport sink (input valid, restart, error_in, step_time, output ready);
endinterface

/* rtl/core/pidc_rsp_if.sv */
`timescale 1ns / 1ps
interface pidc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pidc_pkg::DATA_W-1:0] drive;
   logic [1:0]                        limit_hit;

   modport source (output valid, drive, limit_hit, input ready);
   modport sink (input valid, drive, limit_hit, output ready);
endinterface

/* rtl/core/pid_deadzone_windup_controller.sv */
`timescale 1ns / 1ps
// PID controller with dead band, integral region, output clamp and anti-windup.
// The request channel carries one beat per control sample: restart, the error
// (signed Q16.16) and the step time (unsigned Q0.16). A restart beat clears the
// integral, the previous error and the slope window, and gives no response.
// Every other beat gives exactly one response beat with the clamped drive and
// a limit code. The user must write registers through the csr_ port only while
// idle; the block itself does not enforce it. A bit-serial multiplier forms up
// to five products (the integral step, the integral decay and the three gain
// terms) and a bit-serial divider forms the slope and the window mean; no slope
// is formed on a first step or with a zero step time. One request is worked
// on at a time; the next is taken once the previous result sits in the
// response register. If the receiver stalls, the response holds and the block
// waits before writing a second one. Reset clears the csr registers, the state,
// the integral, the previous error and the slope window count, but not the
// working data registers, the window contents or the response data.
module pid_deadzone_windup_controller (
   input  logic                          clock,
   input  logic                          reset,
   pidc_req_if.sink                      req_bus,
   pidc_rsp_if.source                    rsp_bus,
   input  logic                          csr_we,
   input  logic [2:0]                    csr_index,
   input  logic [pidc_pkg::DATA_W-1:0]   csr_data
);
   import pidc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_INC, S_REGION, S_DECAY, S_DERIV, S_SLOPE, S_SUM,
      S_AVGSTART, S_AVG, S_PSTART, S_PMUL, S_IMUL, S_DMUL, S_FINISH
   } state_type;

   localparam logic signed [DATA_W+1:0] MAX34 = 34'sd2147483647;
   localparam logic signed [DATA_W+1:0] MIN34 = -34'sd2147483648;

   function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DATA_W+1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > MAX34) r = 32'sh7FFF_FFFF;
      else if (v < MIN34) r = 32'sh8000_0000;
      else r = v[DATA_W-1:0];
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] mag_data(input logic signed [DATA_W-1:0] v);
      return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
   endfunction

   logic signed [DATA_W-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic signed [DATA_W-1:0] out_min_ff, out_max_ff;
   logic [LIM_W-1:0]         integ_limit_ff, dead_band_ff, integ_region_ff;

   state_type                state_ff;
   logic signed [DATA_W-1:0] e_ff, inc_ff, accum_ff, last_error_ff, deriv_ff;
   logic [DATA_W-1:0]        emag_ff;
   logic [DT_W-1:0]          dt_ff;
   logic                     first_ff;
   logic signed [DATA_W-1:0] window_ff [FILTER_DEPTH];
   logic [CNT_W-1:0]         slope_count_ff;
   logic [IDX_W-1:0]         slope_head_ff, sum_idx_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [OUT_W-1:0]  out_sum_ff;
   logic                     neg_ff;
   logic                     mul_go_ff, div_go_ff;
   logic [MUL_W-1:0]         mul_a_ff, mul_b_ff;
   logic [DIV_W-1:0]         div_num_ff;
   logic [DEN_W-1:0]         div_den_ff;
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] drive_ff;
   logic [1:0]               hit_ff;

   logic                     mul_done, div_done;
   logic [2*MUL_W-1:0]       mul_prod;
   logic [DIV_W-1:0]         div_quo;

   logic                     accept, rsp_take, in_dead;
   logic [DATA_W-1:0]        in_mag, mul_hi;
   logic signed [DATA_W-1:0] lim, integ_acc, slope, avg, aw_acc;
   logic signed [DATA_W+1:0] lim_w, nlim_w, a1_w;
   logic signed [DATA_W:0]   diff;
   logic [DATA_W:0]          diff_mag;
   logic [SUM_W-1:0]         sum_mag;
   logic [2*MUL_W-FRAC_W-1:0] term_mag;
   logic signed [OUT_W-1:0]  term_s, omax_w, omin_w;
   limit_code_type           hit;
   logic                     aw, s_nz;

   pidc_mul u_mul (
      .clock(clock), .reset(reset), .go(mul_go_ff), .a_mag(mul_a_ff), .b_mag(mul_b_ff),
      .done(mul_done), .prod(mul_prod)
   );

   pidc_div u_div (
      .clock(clock), .reset(reset), .go(div_go_ff), .num(div_num_ff), .den(div_den_ff),
      .done(div_done), .quo(div_quo)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept = req_bus.valid && req_bus.ready;
   assign rsp_take = rsp_bus.valid && rsp_bus.ready;
   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.drive = drive_ff;
   assign rsp_bus.limit_hit = hit_ff;

   always_comb begin
      in_mag = mag_data(req_bus.error_in);
      in_dead = (in_mag < {1'b0, dead_band_ff});
      mul_hi = mul_prod[FRAC_W +: MUL_W];
      term_mag = mul_prod[2*MUL_W-1:FRAC_W];
      term_s = neg_ff ? -$signed({2'b00, term_mag}) : $signed({2'b00, term_mag});

      lim = (integ_limit_ff != '0) ? $signed({1'b0, integ_limit_ff}) : out_max_ff;
      lim_w = (DATA_W+2)'(lim);
      nlim_w = -lim_w;
      a1_w = (DATA_W+2)'(sat_data((DATA_W+2)'(accum_ff) + (DATA_W+2)'(inc_ff)));
      if (a1_w > lim_w) integ_acc = sat_data(lim_w);
      else if (a1_w < nlim_w) integ_acc = sat_data(nlim_w);
      else integ_acc = sat_data(a1_w);

      diff = (DATA_W+1)'(e_ff) - (DATA_W+1)'(last_error_ff);
      diff_mag = diff[DATA_W] ? (DATA_W+1)'(-diff) : (DATA_W+1)'(diff);

      if (!neg_ff) begin
         slope = (|div_quo[DIV_W-1:DATA_W-1]) ? 32'sh7FFF_FFFF : $signed(div_quo[DATA_W-1:0]);
      end else begin
         slope = (div_quo > DIV_W'(33'h0_8000_0000)) ? 32'sh8000_0000
                                                     : $signed(-div_quo[DATA_W-1:0]);
      end
      avg = neg_ff ? $signed(-div_quo[DATA_W-1:0]) : $signed(div_quo[DATA_W-1:0]);
      sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

      omax_w = OUT_W'(out_max_ff);
      omin_w = OUT_W'(out_min_ff);
      if (out_sum_ff > omax_w) hit = HIT_MAX;
      else if (out_sum_ff < omin_w) hit = HIT_MIN;
      else hit = HIT_NONE;
      s_nz = (integ_gain_ff != '0) && (e_ff != '0) && (dt_ff != '0);
      aw = (hit != HIT_NONE) && s_nz &&
           ((integ_gain_ff[DATA_W-1] == e_ff[DATA_W-1]) ? (accum_ff > 0) : (accum_ff < 0));
      aw_acc = sat_data((DATA_W+2)'(accum_ff) - (DATA_W+2)'(inc_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         out_min_ff <= '0;
         out_max_ff <= '0;
         integ_limit_ff <= '0;
         dead_band_ff <= '0;
         integ_region_ff <= '0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_PROP_GAIN:    prop_gain_ff <= csr_data;
            REG_INTEG_GAIN:   integ_gain_ff <= csr_data;
            REG_DERIV_GAIN:   deriv_gain_ff <= csr_data;
            REG_OUT_MIN:      out_min_ff <= csr_data;
            REG_OUT_MAX:      out_max_ff <= csr_data;
            REG_INTEG_LIMIT:  integ_limit_ff <= csr_data[LIM_W-1:0];
            REG_DEAD_BAND:    dead_band_ff <= csr_data[LIM_W-1:0];
            REG_INTEG_REGION: integ_region_ff <= csr_data[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SLOPE && div_done && FILTER_DEPTH > 1) begin
         window_ff[slope_head_ff] <= slope;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         accum_ff <= '0;
         last_error_ff <= '0;
         first_ff <= 1'b1;
         slope_count_ff <= '0;
         slope_head_ff <= '0;
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         if (rsp_take) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_bus.restart) begin
                     accum_ff <= '0;
                     last_error_ff <= '0;
                     first_ff <= 1'b1;
                     slope_count_ff <= '0;
                     slope_head_ff <= '0;
                  end else begin
                     e_ff <= in_dead ? '0 : req_bus.error_in;
                     emag_ff <= in_dead ? '0 : in_mag;
                     dt_ff <= req_bus.step_time;
                     neg_ff <= req_bus.error_in[DATA_W-1] && !in_dead;
                     mul_a_ff <= in_dead ? '0 : in_mag;
                     mul_b_ff <= MUL_W'(req_bus.step_time);
                     mul_go_ff <= 1'b1;
                     state_ff <= S_INC;
                  end
               end
            end
            S_INC: begin
               if (mul_done) begin
                  inc_ff <= neg_ff ? $signed(-mul_hi) : $signed(mul_hi);
                  state_ff <= S_REGION;
               end
            end
            S_REGION: begin
               if (integ_region_ff == '0 || emag_ff < {1'b0, integ_region_ff}) begin
                  accum_ff <= integ_acc;
                  state_ff <= S_DERIV;
               end else begin
                  mul_a_ff <= mag_data(accum_ff);
                  mul_b_ff <= MUL_W'(DECAY_Q16);
                  neg_ff <= accum_ff[DATA_W-1];
                  mul_go_ff <= 1'b1;
                  state_ff <= S_DECAY;
               end
            end
            S_DECAY: begin
               if (mul_done) begin
                  accum_ff <= neg_ff ? $signed(-mul_hi) : $signed(mul_hi);
                  state_ff <= S_DERIV;
               end
            end
            S_DERIV: begin
               if (!first_ff && dt_ff != '0) begin
                  div_num_ff <= {diff_mag, {FRAC_W{1'b0}}};
                  div_den_ff <= DEN_W'(dt_ff);
                  neg_ff <= diff[DATA_W];
                  div_go_ff <= 1'b1;
                  state_ff <= S_SLOPE;
               end else begin
                  deriv_ff <= '0;
                  state_ff <= S_PSTART;
               end
            end
            S_SLOPE: begin
               if (div_done) begin
                  if (FILTER_DEPTH == 1) begin
                     deriv_ff <= slope;
                     state_ff <= S_PSTART;
                  end else begin
                     slope_head_ff <= (slope_head_ff == IDX_W'(FILTER_DEPTH - 1))
                                      ? '0 : slope_head_ff + IDX_W'(1);
                     if (slope_count_ff != CNT_W'(FILTER_DEPTH)) begin
                        slope_count_ff <= slope_count_ff + CNT_W'(1);
                     end
                     sum_ff <= '0;
                     sum_idx_ff <= '0;
                     state_ff <= S_SUM;
                  end
               end
            end
            S_SUM: begin
               sum_ff <= sum_ff + SUM_W'(window_ff[sum_idx_ff]);
               sum_idx_ff <= sum_idx_ff + IDX_W'(1);
               if (CNT_W'(sum_idx_ff) + CNT_W'(1) == slope_count_ff) begin
                  state_ff <= S_AVGSTART;
               end
            end
            S_AVGSTART: begin
               div_num_ff <= DIV_W'(sum_mag);
               div_den_ff <= DEN_W'(slope_count_ff);
               neg_ff <= sum_ff[SUM_W-1];
               div_go_ff <= 1'b1;
               state_ff <= S_AVG;
            end
            S_AVG: begin
               if (div_done) begin
                  deriv_ff <= avg;
                  state_ff <= S_PSTART;
               end
            end
            S_PSTART: begin
               mul_a_ff <= mag_data(prop_gain_ff);
               mul_b_ff <= emag_ff;
               neg_ff <= prop_gain_ff[DATA_W-1] ^ e_ff[DATA_W-1];
               mul_go_ff <= 1'b1;
               state_ff <= S_PMUL;
            end
            S_PMUL: begin
               if (mul_done) begin
                  out_sum_ff <= term_s;
                  mul_a_ff <= mag_data(integ_gain_ff);
                  mul_b_ff <= mag_data(accum_ff);
                  neg_ff <= integ_gain_ff[DATA_W-1] ^ accum_ff[DATA_W-1];
                  mul_go_ff <= 1'b1;
                  state_ff <= S_IMUL;
               end
            end
            S_IMUL: begin
               if (mul_done) begin
                  out_sum_ff <= out_sum_ff + term_s;
                  mul_a_ff <= mag_data(deriv_gain_ff);
                  mul_b_ff <= mag_data(deriv_ff);
                  neg_ff <= deriv_gain_ff[DATA_W-1] ^ deriv_ff[DATA_W-1];
                  mul_go_ff <= 1'b1;
                  state_ff <= S_DMUL;
               end
            end
            S_DMUL: begin
               if (mul_done) begin
                  out_sum_ff <= out_sum_ff + term_s;
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (!rsp_valid_ff || rsp_take) begin
                  unique case (hit)
                     HIT_MAX: drive_ff <= out_max_ff;
                     HIT_MIN: drive_ff <= out_min_ff;
                     default: drive_ff <= out_sum_ff[DATA_W-1:0];
                  endcase
                  hit_ff <= hit;
                  if (aw) accum_ff <= aw_acc;
                  last_error_ff <= e_ff;
                  first_ff <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

/* rtl/core/pidc_mul.sv */
`timescale 1ns / 1ps
module pidc_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           go,
   input  logic [pidc_pkg::MUL_W-1:0]     a_mag,
   input  logic [pidc_pkg::MUL_W-1:0]     b_mag,
   output logic                           done,
   output logic [2*pidc_pkg::MUL_W-1:0]   prod
);
   import pidc_pkg::*;

   localparam int MCNT_W = $clog2(MUL_W + 1);

   logic [MUL_W-1:0]   b_ff;
   logic [2*MUL_W-1:0] prod_ff;
   logic [MCNT_W-1:0]  count_ff;
   logic               done_ff;
   logic [MUL_W:0]     sum_in;

   // One multiplier bit per cycle, shift-add from the low end.
   assign sum_in = {1'b0, prod_ff[2*MUL_W-1:MUL_W]} + (prod_ff[0] ? {1'b0, b_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (count_ff == MCNT_W'(1));
         if (go) begin
            count_ff <= MCNT_W'(MUL_W);
            b_ff <= b_mag;
            prod_ff <= {{MUL_W{1'b0}}, a_mag};
         end else if (count_ff != '0) begin
            count_ff <= count_ff - MCNT_W'(1);
            prod_ff <= {sum_in, prod_ff[MUL_W-1:1]};
         end
      end
   end

   assign done = done_ff;
   assign prod = prod_ff;
endmodule

/* rtl/core/pidc_div.sv */
`timescale 1ns / 1ps
module pidc_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [pidc_pkg::DIV_W-1:0]  num,
   input  logic [pidc_pkg::DEN_W-1:0]  den,
   output logic                        done,
   output logic [pidc_pkg::DIV_W-1:0]  quo
);
   import pidc_pkg::*;

   localparam int DCNT_W = $clog2(DIV_W + 1);

   logic [DEN_W-1:0]  den_ff;
   logic [DEN_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  quo_ff;
   logic [DCNT_W-1:0] count_ff;
   logic              done_ff;
   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;

   // Restoring division, one quotient bit per cycle.
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff = trial - {1'b0, den_ff};
   assign fits = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= (count_ff == DCNT_W'(1));
         if (go) begin
            count_ff <= DCNT_W'(DIV_W);
            den_ff <= den;
            rem_ff <= '0;
            quo_ff <= num;
         end else if (count_ff != '0) begin
            count_ff <= count_ff - DCNT_W'(1);
            rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
         end
      end
   end

   assign done = done_ff;
   assign quo = quo_ff;
endmodule

/* sim/pid_deadzone_windup_controller_test.sv */
`timescale 1ns / 1ps
module pid_deadzone_windup_controller_test;
   import pidc_pkg::*;

   typedef struct packed {
      logic signed [DATA_W-1:0] drive;
      logic [1:0]               limit_hit;
   } drive_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [DATA_W-1:0] csr_data = '0;

   pidc_req_if req_bus ();
   pidc_rsp_if rsp_bus ();

   pid_deadzone_windup_controller u_top (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus.sink),
      .rsp_bus   (rsp_bus.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.restart = 1'b0;
      req_bus.error_in = '0;
      req_bus.step_time = '0;
      rsp_bus.ready = 1'b0;
   end

   longint kp, ki, kd, drive_lo, drive_hi, accum_cap, dead_band, integ_zone;
   longint accum, prev_error;
   bit fresh;
   longint slopes [FILTER_DEPTH];
   int slope_fill, slope_ptr;

   drive_beat_type drive_queue [$];
   int error_count = 0;
   bit quiet = 1'b0;
   int hold_cycles = 0;

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint shr16(longint x);
      return (x < 0) ? -((-x) >>> 16) : (x >>> 16);
   endfunction

   function automatic int sgn(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic void clear_loop();
      accum = 0;
      prev_error = 0;
      fresh = 1'b1;
      slope_fill = 0;
      slope_ptr = 0;
   endfunction

   function automatic void predict_drive(bit restart, logic [DATA_W-1:0] err_bits,
                                         logic [DT_W-1:0] dt_bits);
      longint e, dt, mag, inc, lim, deriv, outv, sum;
      int s;
      drive_beat_type beat;
      beat.limit_hit = HIT_NONE;
      if (restart) begin
         clear_loop();
         return;
      end
      e = longint'($signed(err_bits));
      dt = longint'(dt_bits);
      mag = (e < 0) ? -e : e;
      if (mag < dead_band) begin
         e = 0;
         mag = 0;
      end
      inc = shr16(e * dt);
      if (integ_zone == 0 || mag < integ_zone) begin
         lim = (accum_cap != 0) ? accum_cap : drive_hi;
         accum = sat32(accum + inc);
         if (accum > lim) accum = lim;
         else if (accum < -lim) accum = -lim;
         accum = sat32(accum);
      end else begin
         accum = shr16(accum * longint'(DECAY_Q16));
      end
      deriv = 0;
      if (!fresh && dt > 0) begin
         deriv = sat32(((e - prev_error) * 65536) / dt);
         if (FILTER_DEPTH > 1) begin
            sum = 0;
            slopes[slope_ptr] = deriv;
            slope_ptr = (slope_ptr + 1) % FILTER_DEPTH;
            if (slope_fill < FILTER_DEPTH) slope_fill++;
            for (int i = 0; i < slope_fill; i++) sum += slopes[i];
            deriv = sum / slope_fill;
         end
      end
      fresh = 1'b0;
      outv = shr16(kp * e) + shr16(ki * accum) + shr16(kd * deriv);
      if (outv > drive_hi) begin
         outv = drive_hi;
         beat.limit_hit = HIT_MAX;
      end else if (outv < drive_lo) begin
         outv = drive_lo;
         beat.limit_hit = HIT_MIN;
      end
      if (beat.limit_hit != HIT_NONE) begin
         s = sgn(ki) * sgn(e) * sgn(dt);
         if ((s > 0 && accum > 0) || (s < 0 && accum < 0)) accum = sat32(accum - inc);
      end
      prev_error = e;
      beat.drive = outv[DATA_W-1:0];
      drive_queue.insert(drive_queue.size(), beat);
   endfunction

   function automatic int pick_gap();
      return quiet ? 0 : $urandom_range(0, 11);
   endfunction

   // Response side: random stalls per beat, plus a long hold-off when requested.
   initial begin
      drive_beat_type want;
      int gap;
      gap = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (drive_queue.size() == 0) begin
               $display("%0t: unexpected beat drive=%0d limit_hit=%0d", $time,
                        rsp_bus.drive, rsp_bus.limit_hit);
               error_count++;
            end else begin
               want = drive_queue[0];
               drive_queue.delete(0);
               if (rsp_bus.drive !== want.drive) begin
                  $display("%0t: drive expected %0d actual %0d", $time, want.drive,
                           rsp_bus.drive);
                  error_count++;
               end
               if (rsp_bus.limit_hit !== want.limit_hit) begin
                  $display("%0t: limit_hit expected %0d actual %0d", $time,
                           want.limit_hit, rsp_bus.limit_hit);
                  error_count++;
               end
            end
            gap = pick_gap();
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic send_sample(bit restart, logic [DATA_W-1:0] err, logic [DT_W-1:0] dt);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.restart <= restart;
      req_bus.error_in <= err;
      req_bus.step_time <= dt;
      do @(posedge clock); while (!req_bus.ready);
      predict_drive(restart, err, dt);
   endtask

   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (drive_queue.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_PROP_GAIN:    kp = longint'($signed(value));
         REG_INTEG_GAIN:   ki = longint'($signed(value));
         REG_DERIV_GAIN:   kd = longint'($signed(value));
         REG_OUT_MIN:      drive_lo = longint'($signed(value));
         REG_OUT_MAX:      drive_hi = longint'($signed(value));
         REG_INTEG_LIMIT:  accum_cap = longint'(value[LIM_W-1:0]);
         REG_DEAD_BAND:    dead_band = longint'(value[LIM_W-1:0]);
         default:          integ_zone = longint'(value[LIM_W-1:0]);
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(logic [DATA_W-1:0] p, logic [DATA_W-1:0] i, logic [DATA_W-1:0] d,
                            logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
                            logic [DATA_W-1:0] lim, logic [DATA_W-1:0] db,
                            logic [DATA_W-1:0] zone);
      write_reg(REG_PROP_GAIN, p);
      write_reg(REG_INTEG_GAIN, i);
      write_reg(REG_DERIV_GAIN, d);
      write_reg(REG_OUT_MIN, lo);
      write_reg(REG_OUT_MAX, hi);
      write_reg(REG_INTEG_LIMIT, lim);
      write_reg(REG_DEAD_BAND, db);
      write_reg(REG_INTEG_REGION, zone);
   endtask

   function automatic logic [DATA_W-1:0] rand_error();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) return DATA_W'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
      if (pick < 7) return DATA_W'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17);
      if (pick < 8) return '0;
      return $urandom();
   endfunction

   function automatic logic [DT_W-1:0] rand_step();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      if (pick < 6) return DT_W'($urandom_range(300, 3000));
      return DT_W'($urandom());
   endfunction

   task automatic random_config(int flavor);
      logic [DATA_W-1:0] lo, hi;
      if (flavor == 0) begin
         write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
      end else begin
         lo = -DATA_W'($urandom_range(2 ** 16, 2 ** 24));
         hi = DATA_W'($urandom_range(2 ** 16, 2 ** 24));
         write_all(DATA_W'($signed($urandom_range(0, 2 ** 19)) - 2 ** 18),
                   DATA_W'($signed($urandom_range(0, 2 ** 18)) - 2 ** 17),
                   DATA_W'($signed($urandom_range(0, 2 ** 12)) - 2 ** 11),
                   lo, hi,
                   ($urandom_range(0, 2) == 0) ? '0 : DATA_W'($urandom_range(0, 2 ** 23)),
                   DATA_W'($urandom_range(0, 2 ** 14)),
                   ($urandom_range(0, 1) == 0) ? '0 : DATA_W'($urandom_range(2 ** 16, 2 ** 21)));
      end
   endtask

   task automatic test_directed();
      write_all(32'sd65536, 32'sd32768, 32'sd6554, -32'sd6553600, 32'sd6553600,
                32'd0, 32'd655, 32'd0);
      send_sample(1'b0, 32'sd65536, 16'd655);
      send_sample(1'b0, 32'sd131072, 16'd0);
      send_sample(1'b0, 32'sd131072, 16'd65535);
      send_sample(1'b0, 32'sh7fffffff, 16'd655);
      send_sample(1'b0, 32'sh80000000, 16'd655);
      send_sample(1'b0, 32'sh80000000, 16'd1);
      send_sample(1'b0, 32'sd300, 16'd655);
      send_sample(1'b0, -32'sd300, 16'd655);
      send_sample(1'b0, 32'sd0, 16'd655);
      send_sample(1'b1, 32'sd12345, 16'd655);
      send_sample(1'b0, -32'sd70000, 16'd1000);
      send_sample(1'b0, -32'sd90000, 16'd1000);
      wait_idle();
      write_reg(REG_INTEG_REGION, 32'd200000);
      write_reg(REG_INTEG_LIMIT, 32'd100000);
      send_sample(1'b0, 32'sd150000, 16'd30000);
      send_sample(1'b0, 32'sd150000, 16'd30000);
      send_sample(1'b0, 32'sd500000, 16'd30000);
      send_sample(1'b0, -32'sd500000, 16'd30000);
      wait_idle();
      write_all(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sd65536, -32'sd65536,
                32'd0, 32'd0, 32'h7fffffff);
      send_sample(1'b0, 32'sh7fffffff, 16'd65535);
      send_sample(1'b0, 32'sh80000000, 16'd65535);
      send_sample(1'b0, 32'sd1, 16'd1);
      wait_idle();
      write_all(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                32'h7fffffff, 32'h7fffffff, 32'd1);
      send_sample(1'b0, 32'sh7fffffff, 16'd65535);
      send_sample(1'b0, 32'sh80000000, 16'd1);
      send_sample(1'b0, 32'sd5, 16'd2);
      wait_idle();
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 8; phase++) begin
         quiet = (phase % 4 == 3);
         random_config((phase % 3 == 0) ? 0 : 1);
         for (int n = 0; n < 200; n++)
            send_sample($urandom_range(0, 29) == 0, rand_error(), rand_step());
         wait_idle();
      end
      quiet = 1'b0;
   endtask

   task automatic test_backpressure();
      random_config(1);
      hold_cycles = 3000;
      for (int n = 0; n < 40; n++) send_sample(1'b0, rand_error(), rand_step());
      wait_idle();
   endtask

   initial begin
      clear_loop();
      kp = 0; ki = 0; kd = 0; drive_lo = 0; drive_hi = 0;
      accum_cap = 0; dead_band = 0; integ_zone = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_phases();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
